FILE: rtl/core/ftht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow tuple hash table package
// Shared sizes, field widths, operation and status codes, and the types that
// pass between the modules of the flow table.
// ----------------------------------------------------------------------------
package ftht_pkg;

   // Table geometry. BUCKETS is a power of two, so the bucket index is the
   // low bits of the hash.
   localparam int BUCKETS    = 1024;
   localparam int SLOTS      = 8;
   localparam int BUCKET_W   = $clog2(BUCKETS);
   localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int FILL_W     = $clog2(SLOTS + 1);
   localparam int KEY_DEPTH  = BUCKETS * (1 << SLOT_IDX_W);

   // Divisor that takes the top byte of an address.
   localparam int unsigned TOP_BYTE_DIV = 256 * 256 * 256;

   // Field widths of the item and result ports.
   localparam int ADDR_W   = 32;
   localparam int PORT_W   = 16;
   localparam int STATUS_W = 3;
   localparam int FLOW_W   = 14;

   // Operation codes.
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FOUND     = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd4;

   // One flow key as it is stored in the key memory.
   typedef struct packed {
      logic [ADDR_W-1:0] local_address;
      logic [ADDR_W-1:0] remote_address;
      logic [PORT_W-1:0] lcl_port;
      logic [PORT_W-1:0] rmt_port;
   } flow_key_type;

   localparam int KEY_W = $bits(flow_key_type);

   // Status from the hash unit to the sequencer.
   typedef struct packed {
      logic                done;
      logic [BUCKET_W-1:0] bucket;
   } hash_status_type;

endpackage

FILE: rtl/core/ftht_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow table generic RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ftht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/ftht_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow table hash unit
// Forms the bucket index as the wrapped 32-bit product of the incremented
// address top bytes and ports, one multiply per cycle on a shared multiplier.
// ----------------------------------------------------------------------------
module ftht_hash (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  ftht_pkg::flow_key_type    key,
   output ftht_pkg::hash_status_type status
);

   localparam int BUCKET_W = ftht_pkg::BUCKET_W;
   localparam logic [1:0] STEP_LAST = 2'd2;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [1:0]  step_ff, step_in;
   logic [31:0] acc_ff, acc_in;

   logic [7:0]  la_top;
   logic [7:0]  ra_top;
   logic [16:0] factor;
   logic [48:0] product;

   // Top bytes of the two addresses.
   assign la_top = 8'(key.local_address / ftht_pkg::TOP_BYTE_DIV);
   assign ra_top = 8'(key.remote_address / ftht_pkg::TOP_BYTE_DIV);

   // Factor for the current multiply step.
   always_comb begin
      case (step_ff)
         2'd0:    factor = 17'(ra_top) + 17'd1;
         2'd1:    factor = 17'(key.lcl_port) + 17'd1;
         default: factor = 17'(key.rmt_port) + 17'd1;
      endcase
   end

   assign product = 49'(acc_ff) * 49'(factor);

   // Step control: load the first factor, then three multiplies.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = 2'd0;
         acc_in  = 32'(la_top) + 32'd1;
      end else if (busy_ff) begin
         acc_in  = product[31:0];
         step_in = step_ff + 2'd1;
         if (step_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // The product register needs no reset.
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign status.done   = done_ff;
   assign status.bucket = acc_ff[BUCKET_W-1:0];

endmodule

FILE: rtl/core/flow_tuple_hash_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow tuple hash table unit
// Flow table with bounded chaining: insert and lookup of four-tuple keys.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. It is hashed with
// three multiplies on the shared hash multiplier, its bucket fill count is
// read, and the stored slots of its bucket are compared until the first
// match; an insert into a full bucket skips the compares. The slot compares
// read the key memory one slot a cycle. The result is shown on the rsp_
// ports for one cycle marked by rsp_strobe; the receiver cannot stall, and
// a new item may be started in that same cycle. After reset the block stays
// busy while it clears the bucket fill memory one entry a cycle.
// ----------------------------------------------------------------------------
module flow_tuple_hash_table_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_func,
   input  logic [31:0] req_local_address,
   input  logic [31:0] req_remote_address,
   input  logic [15:0] req_lcl_port,
   input  logic [15:0] req_rmt_port,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [9:0]  rsp_bucket,
   output logic [2:0]  rsp_slot,
   output logic [13:0] rsp_flow_count
);

   localparam int BUCKETS    = ftht_pkg::BUCKETS;
   localparam int SLOTS      = ftht_pkg::SLOTS;
   localparam int BUCKET_W   = ftht_pkg::BUCKET_W;
   localparam int SLOT_IDX_W = ftht_pkg::SLOT_IDX_W;
   localparam int FILL_W     = ftht_pkg::FILL_W;
   localparam int FLOW_W     = ftht_pkg::FLOW_W;
   localparam int KEY_W      = ftht_pkg::KEY_W;
   localparam int KEY_DEPTH  = ftht_pkg::KEY_DEPTH;
   localparam int KEY_ADDR_W = $clog2(KEY_DEPTH);

   localparam logic [BUCKET_W-1:0] BUCKET_LAST = BUCKET_W'(BUCKETS - 1);
   localparam logic [FILL_W-1:0]   FILL_MAX    = FILL_W'(SLOTS);

   // Sequencer states.
   localparam logic [2:0] ST_CLEAR     = 3'd0;
   localparam logic [2:0] ST_IDLE      = 3'd1;
   localparam logic [2:0] ST_HASH_GO   = 3'd2;
   localparam logic [2:0] ST_HASH      = 3'd3;
   localparam logic [2:0] ST_FILL_WAIT = 3'd4;
   localparam logic [2:0] ST_SCAN      = 3'd5;
   localparam logic [2:0] ST_FINISH    = 3'd6;

   // Control registers.
   logic [2:0]          state_ff, state_in;
   logic [BUCKET_W-1:0] clr_ff, clr_in;
   logic                cmp_vld_ff, cmp_vld_in;
   logic                hit_ff, hit_in;
   logic [FLOW_W-1:0]   total_ff, total_in;
   logic                rsp_strobe_ff, rsp_strobe_in;

   // Item and working registers.
   logic                   func_ff, func_in;
   ftht_pkg::flow_key_type key_ff, key_in;
   logic [BUCKET_W-1:0]    bucket_ff, bucket_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [FILL_W-1:0]      issue_ff, issue_in;
   logic [SLOT_IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic [SLOT_IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   logic [2:0]             rsp_status_ff, rsp_status_in;
   logic [9:0]             rsp_bucket_ff, rsp_bucket_in;
   logic [2:0]             rsp_slot_ff, rsp_slot_in;
   logic [13:0]            rsp_flow_count_ff, rsp_flow_count_in;

   // Memory ports.
   logic                  fill_wr_en;
   logic [BUCKET_W-1:0]   fill_wr_addr;
   logic [FILL_W-1:0]     fill_wr_data;
   logic                  fill_rd_en;
   logic [FILL_W-1:0]     fill_rd_data;
   logic                  key_wr_en;
   logic [KEY_ADDR_W-1:0] key_wr_addr;
   logic [KEY_W-1:0]      key_wr_data;
   logic                  key_rd_en;
   logic [KEY_ADDR_W-1:0] key_rd_addr;
   logic [KEY_W-1:0]      key_rd_data;

   logic                      hash_start;
   ftht_pkg::hash_status_type hash_status;

   logic [FILL_W-1:0] fill_clamped;
   logic              key_match;
   logic              cmp_hit;
   logic              more_slots;
   logic              bucket_full;

   // Hash unit.
   ftht_hash u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (hash_start),
      .key    (key_ff),
      .status (hash_status)
   );

   // Per-bucket fill counts.
   ftht_ram #(
      .WIDTH (FILL_W),
      .DEPTH (BUCKETS)
   ) u_fill_ram (
      .clock   (clock),
      .wr_en   (fill_wr_en),
      .wr_addr (fill_wr_addr),
      .wr_data (fill_wr_data),
      .rd_en   (fill_rd_en),
      .rd_addr (hash_status.bucket),
      .rd_data (fill_rd_data)
   );

   // Stored keys, addressed by bucket and slot.
   ftht_ram #(
      .WIDTH (KEY_W),
      .DEPTH (KEY_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_wr_addr),
      .wr_data (key_wr_data),
      .rd_en   (key_rd_en),
      .rd_addr (key_rd_addr),
      .rd_data (key_rd_data)
   );

   // Shared key compare and the fill count limits.
   assign fill_clamped = (fill_rd_data > FILL_MAX) ? FILL_MAX : fill_rd_data;
   assign key_match    = (key_rd_data == key_ff);
   assign cmp_hit      = cmp_vld_ff && key_match;
   assign more_slots   = (issue_ff < fill_ff);
   assign bucket_full  = (fill_ff >= FILL_MAX);
   assign key_wr_data  = key_ff;
   assign key_wr_addr  = {bucket_ff, fill_ff[SLOT_IDX_W-1:0]};
   assign key_rd_addr  = {bucket_ff, issue_ff[SLOT_IDX_W-1:0]};

   // Sequencer.
   always_comb begin
      state_in          = state_ff;
      clr_in            = clr_ff;
      cmp_vld_in        = cmp_vld_ff;
      hit_in            = hit_ff;
      total_in          = total_ff;
      rsp_strobe_in     = 1'b0;
      func_in           = func_ff;
      key_in            = key_ff;
      bucket_in         = bucket_ff;
      fill_in           = fill_ff;
      issue_in          = issue_ff;
      cmp_idx_in        = cmp_idx_ff;
      hit_idx_in        = hit_idx_ff;
      rsp_status_in     = rsp_status_ff;
      rsp_bucket_in     = rsp_bucket_ff;
      rsp_slot_in       = rsp_slot_ff;
      rsp_flow_count_in = rsp_flow_count_ff;
      fill_wr_en        = 1'b0;
      fill_wr_addr      = bucket_ff;
      fill_wr_data      = '0;
      fill_rd_en        = 1'b0;
      key_wr_en         = 1'b0;
      key_rd_en         = 1'b0;
      hash_start        = 1'b0;

      unique case (state_ff)
         // After reset, clear the fill memory one bucket a cycle.
         ST_CLEAR: begin
            fill_wr_en   = 1'b1;
            fill_wr_addr = clr_ff;
            clr_in       = clr_ff + BUCKET_W'(1);
            if (clr_ff == BUCKET_LAST) begin
               state_in = ST_IDLE;
            end
         end

         // Take a new item.
         ST_IDLE: begin
            if (start) begin
               func_in                  = req_func;
               key_in.local_address     = req_local_address;
               key_in.remote_address    = req_remote_address;
               key_in.lcl_port          = req_lcl_port;
               key_in.rmt_port          = req_rmt_port;
               state_in                 = ST_HASH_GO;
            end
         end

         ST_HASH_GO: begin
            hash_start = 1'b1;
            state_in   = ST_HASH;
         end

         // Wait for the bucket index, then read its fill count.
         ST_HASH: begin
            if (hash_status.done) begin
               fill_rd_en = 1'b1;
               bucket_in  = hash_status.bucket;
               state_in   = ST_FILL_WAIT;
            end
         end

         // An insert into a full bucket needs no scan.
         ST_FILL_WAIT: begin
            fill_in    = fill_clamped;
            issue_in   = '0;
            cmp_vld_in = 1'b0;
            hit_in     = 1'b0;
            hit_idx_in = '0;
            if ((func_ff == ftht_pkg::FUNC_INSERT) && (fill_clamped == FILL_MAX)) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SCAN;
            end
         end

         // Read one slot a cycle and compare the slot read the cycle before.
         ST_SCAN: begin
            cmp_vld_in = 1'b0;
            if (more_slots && !cmp_hit) begin
               key_rd_en  = 1'b1;
               issue_in   = issue_ff + FILL_W'(1);
               cmp_vld_in = 1'b1;
               cmp_idx_in = issue_ff[SLOT_IDX_W-1:0];
            end
            if (cmp_hit) begin
               hit_in     = 1'b1;
               hit_idx_in = cmp_idx_ff;
               state_in   = ST_FINISH;
            end else if (!more_slots) begin
               state_in = ST_FINISH;
            end
         end

         // Decide the status, update the table and register the result.
         ST_FINISH: begin
            rsp_strobe_in = 1'b1;
            rsp_bucket_in = 10'(bucket_ff);
            rsp_slot_in   = 3'd0;
            if (func_ff == ftht_pkg::FUNC_LOOKUP) begin
               if (hit_ff) begin
                  rsp_status_in = ftht_pkg::STATUS_FOUND;
                  rsp_slot_in   = 3'(hit_idx_ff);
               end else begin
                  rsp_status_in = ftht_pkg::STATUS_NOT_FOUND;
               end
            end else if (bucket_full) begin
               rsp_status_in = ftht_pkg::STATUS_FULL;
            end else if (hit_ff) begin
               rsp_status_in = ftht_pkg::STATUS_DUPLICATE;
            end else begin
               rsp_status_in = ftht_pkg::STATUS_INSERTED;
               rsp_slot_in   = 3'(fill_ff);
               key_wr_en     = 1'b1;
               fill_wr_en    = 1'b1;
               fill_wr_data  = fill_ff + FILL_W'(1);
               total_in      = total_ff + FLOW_W'(1);
            end
            rsp_flow_count_in = 14'(total_in);
            state_in          = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         cmp_vld_ff    <= 1'b0;
         hit_ff        <= 1'b0;
         total_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         cmp_vld_ff    <= cmp_vld_in;
         hit_ff        <= hit_in;
         total_ff      <= total_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      func_ff           <= func_in;
      key_ff            <= key_in;
      bucket_ff         <= bucket_in;
      fill_ff           <= fill_in;
      issue_ff          <= issue_in;
      cmp_idx_ff        <= cmp_idx_in;
      hit_idx_ff        <= hit_idx_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_bucket_ff     <= rsp_bucket_in;
      rsp_slot_ff       <= rsp_slot_in;
      rsp_flow_count_ff <= rsp_flow_count_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_bucket     = rsp_bucket_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_flow_count = rsp_flow_count_ff;

endmodule

FILE: rtl/core/ftht_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow table port checker
// Concurrent checks on the ports of the flow table unit, bound to its top.
// ----------------------------------------------------------------------------
module ftht_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [2:0]  rsp_status,
   input logic [2:0]  rsp_slot,
   input logic [13:0] rsp_flow_count
);

   // A taken item keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after an item was taken");

   // A result appears only once the block is ready again.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while the block is busy");

   // Each item passes through the hash and finish states, so results never come back to back.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("results on two consecutive cycles");

   // Refused inserts and missed lookups report slot zero.
   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && ((rsp_status == ftht_pkg::STATUS_DUPLICATE) ||
                      (rsp_status == ftht_pkg::STATUS_FULL) ||
                      (rsp_status == ftht_pkg::STATUS_NOT_FOUND)))
      |-> (rsp_slot == 3'd0))
      else $error("nonzero slot on a result without a slot");

   // A successful insert leaves at least one flow in the table.
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == ftht_pkg::STATUS_INSERTED))
      |-> (rsp_flow_count != 14'd0))
      else $error("flow count zero after an insert");

endmodule

bind flow_tuple_hash_table_unit ftht_checker u_ftht_checker (.*);

FILE: verif/flow_tuple_hash_table_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow tuple hash table checker
// Watches the item and result channels of the flow table and predicts every
// result from its own copy of the table. It compares each result field by
// field with the oldest prediction and counts the mismatches.
// ----------------------------------------------------------------------------
module flow_tuple_hash_table_unit_checker
   import ftht_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic                req_func,
   input  logic [ADDR_W-1:0]   req_local_address,
   input  logic [ADDR_W-1:0]   req_remote_address,
   input  logic [PORT_W-1:0]   req_lcl_port,
   input  logic [PORT_W-1:0]   req_rmt_port,
   input  logic                rsp_strobe,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic [BUCKET_W-1:0] rsp_bucket,
   input  logic [SLOT_IDX_W-1:0] rsp_slot,
   input  logic [FLOW_W-1:0]   rsp_flow_count,
   output int                  failures,
   output int                  pending
);

   // One predicted result.
   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [BUCKET_W-1:0]   bucket;
      logic [SLOT_IDX_W-1:0] slot;
      logic [FLOW_W-1:0]     flow_count;
   } flow_answer_type;

   // Private copy of the table contents.
   flow_key_type    table_keys [BUCKETS][SLOTS];
   int unsigned     table_fill [BUCKETS];
   int unsigned     table_flows;
   flow_answer_type answers_due [$];
   int              mismatch_count = 0;
   int              results_seen = 0;

   assign failures = mismatch_count;

   // Prints one failure line and counts it.
   task automatic report_failure(string message);
      $display("%0t ns: result %0d: %s", $time, results_seen, message);
      mismatch_count++;
   endtask

   // Bucket of a key: wrapped 32-bit product of the top address bytes and
   // the ports, each plus one, taken modulo the bucket count.
   function automatic int unsigned bucket_of_key(flow_key_type key);
      logic [31:0] product;
      product = key.local_address / TOP_BYTE_DIV + 32'd1;
      product = product * (key.remote_address / TOP_BYTE_DIV + 32'd1);
      product = product * ({16'd0, key.lcl_port} + 32'd1);
      product = product * ({16'd0, key.rmt_port} + 32'd1);
      return product % BUCKETS;
   endfunction

   // Applies one insert or lookup to the table copy and returns its result.
   function automatic flow_answer_type apply_flow_op(logic func, flow_key_type key);
      flow_answer_type answer;
      int unsigned     bucket;
      int unsigned     fill;
      int unsigned     hit;
      bucket = bucket_of_key(key);
      fill   = table_fill[bucket];
      hit    = SLOTS;
      for (int s = 0; s < fill; s++) begin
         if (hit == SLOTS && table_keys[bucket][s] == key) begin
            hit = s;
         end
      end
      answer.bucket = BUCKET_W'(bucket);
      answer.slot   = '0;
      if (func == FUNC_LOOKUP) begin
         if (hit < SLOTS) begin
            answer.status = STATUS_FOUND;
            answer.slot   = SLOT_IDX_W'(hit);
         end else begin
            answer.status = STATUS_NOT_FOUND;
         end
      end else if (fill >= SLOTS) begin
         // A full bucket refuses even a key it already holds.
         answer.status = STATUS_FULL;
      end else if (hit < SLOTS) begin
         answer.status = STATUS_DUPLICATE;
      end else begin
         table_keys[bucket][fill] = key;
         table_fill[bucket]       = fill + 1;
         table_flows++;
         answer.status = STATUS_INSERTED;
         answer.slot   = SLOT_IDX_W'(fill);
      end
      answer.flow_count = FLOW_W'(table_flows);
      return answer;
   endfunction

   // Results are compared before a new item is predicted, since a result
   // and the next item can meet on the same edge.
   always @(posedge clock) begin : watch_channels
      flow_key_type    key;
      flow_answer_type want;
      if (reset) begin
         foreach (table_fill[b]) table_fill[b] = 0;
         table_flows = 0;
         answers_due.delete();
         pending <= 0;
      end else begin
         if (rsp_strobe) begin
            results_seen++;
            if (answers_due.size() == 0) begin
               report_failure("result with no item outstanding");
            end else begin
               want = answers_due.pop_front();
               if (rsp_status !== want.status)
                  report_failure($sformatf("status expected %0d, got %0d",
                                           want.status, rsp_status));
               if (rsp_bucket !== want.bucket)
                  report_failure($sformatf("bucket expected %0d, got %0d",
                                           want.bucket, rsp_bucket));
               if (rsp_slot !== want.slot)
                  report_failure($sformatf("slot expected %0d, got %0d",
                                           want.slot, rsp_slot));
               if (rsp_flow_count !== want.flow_count)
                  report_failure($sformatf("flow count expected %0d, got %0d",
                                           want.flow_count, rsp_flow_count));
            end
         end
         if (start && !busy) begin
            key.local_address  = req_local_address;
            key.remote_address = req_remote_address;
            key.lcl_port       = req_lcl_port;
            key.rmt_port       = req_rmt_port;
            answers_due.push_back(apply_flow_op(req_func, key));
         end
         pending <= answers_due.size();
      end
   end

endmodule

FILE: verif/flow_tuple_hash_table_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow tuple hash table testbench
// Drives inserts and lookups into the flow table: a directed part that fills
// one bucket past its end, then random phases with keys drawn from a few
// bucket families so that buckets fill, duplicates and lookups hit, under
// several rates of sender idling. The checker beside the block predicts and
// compares every result.
// ----------------------------------------------------------------------------
module flow_tuple_hash_table_unit_test;
   import ftht_pkg::*;

   localparam int FAMILIES = 8;
   localparam int MAX_GAP  = 60;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_func = FUNC_INSERT;
   logic [ADDR_W-1:0]     req_local_address = '0;
   logic [ADDR_W-1:0]     req_remote_address = '0;
   logic [PORT_W-1:0]     req_lcl_port = '0;
   logic [PORT_W-1:0]     req_rmt_port = '0;
   logic                  rsp_strobe;
   logic [STATUS_W-1:0]   rsp_status;
   logic [BUCKET_W-1:0]   rsp_bucket;
   logic [SLOT_IDX_W-1:0] rsp_slot;
   logic [FLOW_W-1:0]     rsp_flow_count;
   int                    failures;
   int                    pending;

   // Key families share top address bytes and ports, hence one bucket.
   flow_key_type family_base [FAMILIES];
   flow_key_type inserted_keys [$];
   int           idle_percent = 0;

   always #6 clock = ~clock;

   flow_tuple_hash_table_unit dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_func           (req_func),
      .req_local_address  (req_local_address),
      .req_remote_address (req_remote_address),
      .req_lcl_port       (req_lcl_port),
      .req_rmt_port       (req_rmt_port),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_bucket         (rsp_bucket),
      .rsp_slot           (rsp_slot),
      .rsp_flow_count     (rsp_flow_count)
   );

   flow_tuple_hash_table_unit_checker flow_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_func           (req_func),
      .req_local_address  (req_local_address),
      .req_remote_address (req_remote_address),
      .req_lcl_port       (req_lcl_port),
      .req_rmt_port       (req_rmt_port),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_bucket         (rsp_bucket),
      .rsp_slot           (rsp_slot),
      .rsp_flow_count     (rsp_flow_count),
      .failures           (failures),
      .pending            (pending)
   );

   function automatic flow_key_type make_key(logic [31:0] la, logic [31:0] ra,
                                             logic [15:0] lp, logic [15:0] rp);
      flow_key_type key;
      key.local_address  = la;
      key.remote_address = ra;
      key.lcl_port       = lp;
      key.rmt_port       = rp;
      return key;
   endfunction

   // A fresh key in a random family: only the low address bytes vary.
   function automatic flow_key_type family_key();
      flow_key_type key;
      key = family_base[$urandom_range(FAMILIES - 1)];
      key.local_address[23:0]  = 24'($urandom);
      key.remote_address[23:0] = 24'($urandom);
      return key;
   endfunction

   // Presents one item and returns at the edge that accepts it.
   task automatic send_item(logic func, flow_key_type key);
      start              <= 1'b1;
      req_func           <= func;
      req_local_address  <= key.local_address;
      req_remote_address <= key.remote_address;
      req_lcl_port       <= key.lcl_port;
      req_rmt_port       <= key.rmt_port;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (func == FUNC_INSERT) inserted_keys.push_back(key);
   endtask

   // Random sender gap of geometric length at the current idle rate.
   task automatic sender_gap();
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_percent) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Holds the sender off until every outstanding result has come back.
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Mostly well-formed traffic on a few crowded buckets, some noise.
   task automatic random_item();
      flow_key_type key;
      logic         func;
      int           pick;
      pick = $urandom_range(99);
      if (pick < 40 || inserted_keys.size() == 0) begin
         key  = family_key();
         func = FUNC_INSERT;
      end else if (pick < 55) begin
         key  = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
         func = FUNC_INSERT;
      end else if (pick < 80) begin
         key  = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
         func = FUNC_LOOKUP;
      end else if (pick < 90) begin
         key  = family_key();
         func = FUNC_LOOKUP;
      end else begin
         key  = make_key($urandom, $urandom, 16'($urandom), 16'($urandom));
         func = $urandom_range(1) ? FUNC_LOOKUP : FUNC_INSERT;
      end
      send_item(func, key);
   endtask

   // One random phase on new families, ending with all results returned.
   task automatic run_phase(int items, int percent);
      idle_percent = percent;
      foreach (family_base[f]) begin
         family_base[f] = make_key($urandom, $urandom, 16'($urandom), 16'($urandom));
      end
      repeat (items) begin
         sender_gap();
         random_item();
      end
      drain_results();
   endtask

   // Watchdog for a hung run.
   initial begin
      #5000000;
      $display("flow_tuple_hash_table_unit_test failed");
      $finish;
   end

   initial begin : stimulus
      flow_key_type zero_key;
      flow_key_type ones_key;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Extremes of every field, including a lookup in an empty bucket and
      // a repeated insert of the same key.
      zero_key = make_key('0, '0, '0, '0);
      ones_key = make_key('1, '1, '1, '1);
      send_item(FUNC_LOOKUP, zero_key);
      send_item(FUNC_INSERT, zero_key);
      send_item(FUNC_INSERT, ones_key);
      send_item(FUNC_LOOKUP, zero_key);
      send_item(FUNC_LOOKUP, ones_key);
      send_item(FUNC_INSERT, zero_key);

      // Fill one bucket to the last slot, with a duplicate on the way.
      for (int i = 0; i < SLOTS; i++) begin
         if (i == 4) begin
            send_item(FUNC_INSERT, make_key(32'h0A00_0001, 32'hC0A8_0001, 16'd80, 16'd443));
         end
         send_item(FUNC_INSERT, make_key(32'h0A00_0000 | i, 32'hC0A8_0001, 16'd80, 16'd443));
      end

      // A full bucket refuses new keys and present keys alike; lookups still
      // find the first and last slots and miss an absent key.
      send_item(FUNC_INSERT, make_key(32'h0A00_0100, 32'hC0A8_0001, 16'd80, 16'd443));
      send_item(FUNC_INSERT, make_key(32'h0A00_0003, 32'hC0A8_0001, 16'd80, 16'd443));
      send_item(FUNC_LOOKUP, make_key(32'h0A00_0007, 32'hC0A8_0001, 16'd80, 16'd443));
      send_item(FUNC_LOOKUP, make_key(32'h0A00_0000, 32'hC0A8_0001, 16'd80, 16'd443));
      send_item(FUNC_LOOKUP, make_key(32'h0AFF_FFFF, 32'hC0A8_0001, 16'd80, 16'd443));
      drain_results();

      // Random phases under different sender idle rates.
      run_phase(200, 0);
      run_phase(160, 78);
      run_phase(200, 9);
      run_phase(140, 0);

      // Let any stray result show up before the verdict.
      repeat (24) @(posedge clock);
      if (failures == 0) begin
         $display("flow_tuple_hash_table_unit_test passed");
      end else begin
         $display("flow_tuple_hash_table_unit_test failed");
      end
      $finish;
   end

endmodule
